// ----- hdl/mtrlp_pkg.sv -----
// ----------------------------------------------------------------------------
// mtrlp_pkg: shared types and constants for the tile row line plotter
// Field positions, operation codes, register indexes, reset values and the
// grey-to-RGB colour helpers used by the core, its lanes and its checker.
// ----------------------------------------------------------------------------
package mtrlp_pkg;

    // Line geometry
    localparam int LINE_WIDTH_DEF = 160;
    localparam int NUM_LANES      = 8;    // one lane per pixel of a tile row
    localparam int LANE_W         = 3;    // x[2:0] selects the lane
    localparam int ROW_BITS       = 5;    // x[7:3] selects the row in a lane

    // Stream widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    // Input tdata field positions
    localparam int TD_SCANLINE_LSB = 0;
    localparam int TD_TILE_X_LSB   = 8;
    localparam int TD_PATTERN_LSB  = 16;
    localparam int TD_MIRROR_LSB   = 32;
    localparam int TD_PAL_SEL_LSB  = 33;
    localparam int TD_PAL_HIGH_LSB = 35;
    localparam int TD_DEPTH_LSB    = 36;
    localparam int TD_READ_X_LSB   = 44;

    // Operation codes (tuser)
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PLOT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 54;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NEGATIVE_MODE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_COLOUR = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_CONTROL    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTES      = 3'd7;

    localparam logic [7:0] WINDOW_WIDTH_RST  = 8'd160;
    localparam logic [7:0] WINDOW_HEIGHT_RST = 8'd152;

    // Colour constants
    localparam logic [15:0] BACK_DEFAULT   = 16'h0FFF;
    localparam logic [7:0]  BG_ENABLE_MASK = 8'hC0;
    localparam logic [7:0]  BG_ENABLE_CODE = 8'h80;
    localparam logic [1:0]  PAL_SPRITE     = 2'd2;

    // Pixel write command for one lane
    typedef struct packed {
        logic        plot;
        logic [7:0]  depth;
        logic [15:0] colour;
    } pix_t;

    // Stored entry as read back from one lane
    typedef struct packed {
        logic        valid;
        logic [7:0]  depth;
        logic [15:0] colour;
    } entry_t;

    // Line fill captured at start of line; unwritten entries read as this
    typedef struct packed {
        logic        started;
        logic        rows;
        logic [7:0]  win_x;
        logic [7:0]  win_w;
        logic [15:0] back;
        logic [15:0] outer;
    } fill_t;

    // 3-bit grey replicated into the R, G and B nibbles
    function automatic logic [15:0] grey_word(input logic [2:0] g);
        return {4'b0000, g, 1'b0, g, 1'b0, g, 1'b0};
    endfunction

    // Complemented unless negative mode is set
    function automatic logic [15:0] shade(input logic [2:0] g, input logic neg);
        logic [15:0] w;
        w = grey_word(g);
        return neg ? w : ~w;
    endfunction

endpackage

// ----- hdl/mono_tile_row_line_plotter_core.sv -----
// ----------------------------------------------------------------------------
// mono_tile_row_line_plotter_core: scanline line buffer compositor
// Input stream items (tuser = operation) start a line, plot one 2-bit tile
// row, or read one pixel. Reads return colour and depth on the output stream.
// Configuration is written through a plain write port (cfg_we/index/wdata);
// the user is to write it only while the block is idle; the block does not enforce this.
//
// Each item goes through a fetch step, which reads the eight target pixels from
// the eight lane banks (one pixel per bank, banked on x[2:0]), and then a step
// that depth-tests and writes back; a new item is taken only once the last is
// through. A read result is loaded into the output register as its write-back
// completes. Start of line clears the per-row valid bits and captures the line
// fill; entries not written since then read back as that fill with depth zero.
//
// Reset clears the valid bits, configuration and line fill; no clearing pass is needed.
// While the receiver stalls, plot and start items are still taken; a read
// item waits in its write-back cycle until the output register frees up.
// ----------------------------------------------------------------------------
module mono_tile_row_line_plotter_core import mtrlp_pkg::*; #(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // scanline[7:0], tile_x[15:8], pattern_row[31:16], mirror[32],
    // palette_select[34:33], palette_high[35], depth[43:36], read_x[51:44]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0]   s_tuser,   // operation[1:0]
    // Results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // pixel_colour[15:0], pixel_depth[23:16]
    // Configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int BANK_DEPTH = (LINE_WIDTH + NUM_LANES - 1) / NUM_LANES;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_COMMIT = 1'b1;

    // Configuration registers
    logic [7:0]            wx_reg, wy_reg, ww_reg, wh_reg;
    logic                  neg_reg;
    logic [2:0]            wcol_reg;
    logic [7:0]            bgc_reg;
    logic [CFG_DATA_W-1:0] pal_reg;

    // Control
    logic       state_reg, state_next;
    logic       accept, done, out_free;
    logic       do_start, do_plot, do_read;
    logic [1:0] op_reg;
    logic [7:0] scan_reg, rx_reg;
    fill_t      fill_reg, fill_next;

    // Input fields
    logic [1:0]  in_op;
    logic [7:0]  in_tile_x, in_depth, in_read_x;
    logic [15:0] in_pattern;
    logic        in_mirror, in_pal_high;
    logic [1:0]  in_pal_sel, pal_eff;

    // Lanes
    pix_t                   pix_d   [NUM_LANES];
    pix_t                   pix_reg [NUM_LANES];
    logic [ROW_BITS-1:0]    row_d   [NUM_LANES];
    entry_t [NUM_LANES-1:0] ents;

    assign in_op       = s_tuser[1:0];
    assign in_tile_x   = s_tdata[TD_TILE_X_LSB +: 8];
    assign in_pattern  = s_tdata[TD_PATTERN_LSB +: 16];
    assign in_mirror   = s_tdata[TD_MIRROR_LSB];
    assign in_pal_sel  = s_tdata[TD_PAL_SEL_LSB +: 2];
    assign in_pal_high = s_tdata[TD_PAL_HIGH_LSB];
    assign in_depth    = s_tdata[TD_DEPTH_LSB +: 8];
    assign in_read_x   = s_tdata[TD_READ_X_LSB +: 8];
    assign pal_eff     = (in_pal_sel > PAL_SPRITE) ? PAL_SPRITE : in_pal_sel;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wx_reg   <= 8'd0;
            wy_reg   <= 8'd0;
            ww_reg   <= WINDOW_WIDTH_RST;
            wh_reg   <= WINDOW_HEIGHT_RST;
            neg_reg  <= 1'b0;
            wcol_reg <= 3'd0;
            bgc_reg  <= 8'd0;
            pal_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WINDOW_X:      wx_reg   <= cfg_wdata[7:0];
                REG_WINDOW_Y:      wy_reg   <= cfg_wdata[7:0];
                REG_WINDOW_WIDTH:  ww_reg   <= cfg_wdata[7:0];
                REG_WINDOW_HEIGHT: wh_reg   <= cfg_wdata[7:0];
                REG_NEGATIVE_MODE: neg_reg  <= cfg_wdata[0];
                REG_WINDOW_COLOUR: wcol_reg <= cfg_wdata[2:0];
                REG_BG_CONTROL:    bgc_reg  <= cfg_wdata[7:0];
                REG_PALETTES:      pal_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer: fetch cycle on transfer, then write-back cycle
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign done     = (state_reg == ST_COMMIT) && ((op_reg != OP_READ) || out_free);
    assign do_start = done && (op_reg == OP_START);
    assign do_plot  = done && (op_reg == OP_PLOT);
    assign do_read  = done && (op_reg == OP_READ);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_COMMIT;
            ST_COMMIT: if (done)   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= in_op;
            scan_reg <= s_tdata[TD_SCANLINE_LSB +: 8];
            rx_reg   <= in_read_x;
        end
    end

    // Line fill captured at start of line
    always_comb begin
        logic [15:0] back0;
        back0 = ((bgc_reg & BG_ENABLE_MASK) == BG_ENABLE_CODE) ?
                ~grey_word(bgc_reg[2:0]) : BACK_DEFAULT;
        fill_next.started = 1'b1;
        fill_next.rows    = ({1'b0, scan_reg} >= {1'b0, wy_reg}) &&
                            ({1'b0, scan_reg} < ({1'b0, wy_reg} + {1'b0, wh_reg}));
        fill_next.win_x   = wx_reg;
        fill_next.win_w   = ww_reg;
        fill_next.back    = neg_reg ? ~back0 : back0;
        fill_next.outer   = shade(wcol_reg, neg_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (do_start) begin
            fill_reg <= fill_next;
        end
    end

    // Lanes: lane b takes the pixel whose x has x[2:0] == b
    for (genvar b = 0; b < NUM_LANES; b++) begin : g_lane
        logic [2:0]  ofs, k, ent_sel, grey;
        logic [7:0]  px;
        logic [1:0]  idx;
        logic [5:0]  bit_ofs;
        logic        win;
        pix_t        pix_b;

        always_comb begin
            ofs     = 3'(b) - in_tile_x[2:0];
            px      = in_tile_x + {5'b00000, ofs};
            k       = in_mirror ? (3'd7 - ofs) : ofs;
            idx     = in_pattern[{3'd7 - k, 1'b0} +: 2];
            win     = (px >= wx_reg) &&
                      ({1'b0, px} < ({1'b0, wx_reg} + {1'b0, ww_reg})) &&
                      ({1'b0, px} < 9'(LINE_WIDTH));
            ent_sel = in_pal_high ? (3'(idx) + 3'd2) : (3'(idx) - 3'd1);
            bit_ofs = (6'(pal_eff) * 6'd6 + 6'(ent_sel)) * 6'd3;
            grey    = pal_reg[bit_ofs +: 3];
            pix_b   = '{plot:   (in_op == OP_PLOT) && (idx != 2'd0) && win,
                        depth:  in_depth,
                        colour: shade(grey, neg_reg)};
        end

        assign pix_d[b] = pix_b;
        assign row_d[b] = (in_op == OP_READ) ? in_read_x[7:3] : px[7:3];

        always_ff @(posedge aclk) begin
            if (accept) begin
                pix_reg[b] <= pix_d[b];
            end
        end

        mtrlp_lane #(
            .BANK_DEPTH (BANK_DEPTH)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .rd_en   (accept),
            .rd_row  (row_d[b]),
            .clear   (do_start),
            .commit  (do_plot),
            .pix     (pix_reg[b]),
            .ent     (ents[b])
        );
    end

    // Read merge and output register
    mtrlp_merge #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ents     (ents),
        .load     (do_read),
        .rx       (rx_reg),
        .fill     (fill_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .out_free (out_free)
    );

endmodule

// ----- hdl/mtrlp_ram.sv -----
// ----------------------------------------------------------------------------
// mtrlp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mtrlp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 20,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mtrlp_lane.sv -----
// ----------------------------------------------------------------------------
// mtrlp_lane: one pixel lane of the line buffer
// Holds every eighth pixel of the line (colour and depth) in a RAM bank with
// per-row valid bits, and does the depth test and write for its pixel.
// ----------------------------------------------------------------------------
module mtrlp_lane import mtrlp_pkg::*; #(
    parameter int BANK_DEPTH = (LINE_WIDTH_DEF + NUM_LANES - 1) / NUM_LANES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,     // item accepted: fetch row
    input  logic [ROW_BITS-1:0] rd_row,
    input  logic                clear,     // start of line: drop all rows
    input  logic                commit,    // plot write phase
    input  pix_t                pix,
    output entry_t              ent
);

    localparam int ROW_W   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int VALID_N = 1 << ROW_W;

    logic [ROW_W-1:0]   row_reg;
    logic [VALID_N-1:0] valid_reg, valid_next;
    logic [23:0]        rd_data;
    logic               cur_valid;
    logic [7:0]         cur_depth;
    logic               wr_en;

    // Row of the item in flight
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            row_reg <= rd_row[ROW_W-1:0];
        end
    end

    // Depth test; an unwritten row has depth zero
    assign cur_valid = valid_reg[row_reg];
    assign cur_depth = cur_valid ? rd_data[23:16] : 8'd0;
    assign wr_en     = commit && pix.plot && (pix.depth > cur_depth);

    // Valid bits
    always_comb begin
        valid_next = valid_reg;
        if (clear) begin
            valid_next = '0;
        end else if (wr_en) begin
            valid_next[row_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    mtrlp_ram #(
        .WIDTH (24),
        .DEPTH (BANK_DEPTH)
    ) u_bank (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (row_reg),
        .wdata ({pix.depth, pix.colour}),
        .re    (rd_en),
        .raddr (rd_row[ROW_W-1:0]),
        .rdata (rd_data)
    );

    assign ent = '{valid: cur_valid, depth: rd_data[23:16], colour: rd_data[15:0]};

endmodule

// ----- hdl/mtrlp_merge.sv -----
// ----------------------------------------------------------------------------
// mtrlp_merge: read-out merge and output register
// Picks the lane that holds the requested pixel, substitutes the line fill
// for entries not written since start of line, and holds the result.
// ----------------------------------------------------------------------------
module mtrlp_merge import mtrlp_pkg::*; #(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  entry_t [NUM_LANES-1:0]        ents,
    input  logic                          load,
    input  logic [7:0]                    rx,
    input  fill_t                         fill,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [M_TDATA_W-1:0]          m_tdata,
    output logic                          out_free
);

    entry_t          sel;
    logic            in_line;
    logic            fill_in;
    logic [15:0]     fill_colour;
    logic [15:0]     colour_d;
    logic [7:0]      depth_d;
    logic            m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Lane select and fill substitution
    always_comb begin
        sel     = ents[rx[LANE_W-1:0]];
        in_line = ({1'b0, rx} < 9'(LINE_WIDTH));
        fill_in = fill.rows && (rx >= fill.win_x) &&
                  ({1'b0, rx} < ({1'b0, fill.win_x} + {1'b0, fill.win_w}));
        if (!fill.started) begin
            fill_colour = 16'd0;
        end else if (fill_in) begin
            fill_colour = fill.back;
        end else begin
            fill_colour = fill.outer;
        end
        if (!in_line) begin
            colour_d = 16'd0;
            depth_d  = 8'd0;
        end else if (sel.valid) begin
            colour_d = sel.colour;
            depth_d  = sel.depth;
        end else begin
            colour_d = fill_colour;
            depth_d  = 8'd0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {depth_d, colour_d};
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hdl/mtrlp_checker.sv -----
// ----------------------------------------------------------------------------
// mtrlp_checker: port-level assertions for the line plotter core
// Watches the stream and checks item pacing and read results over time.
// ----------------------------------------------------------------------------
module mtrlp_checker import mtrlp_pkg::*; #(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // One item in flight: ready drops after each input transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    // A new result follows a read item transfer
    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == OP_READ), 2))
        else $error("result without a matching read item");

    // Reads beyond the line return zero colour and depth
    a_read_out_of_line: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid) && ($past(s_tdata[TD_READ_X_LSB +: 8], 2) >= LINE_WIDTH))
        |-> (m_tdata == '0))
        else $error("out-of-line read returned nonzero data");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind mono_tile_row_line_plotter_core mtrlp_checker #(
    .LINE_WIDTH (LINE_WIDTH)
) u_mtrlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tile row line plotter core
// Drives start-line, plot and read items on the input stream, predicts each
// untyped read result with its own line-buffer model, and compares each result
// transfer field by field. Runs a short directed table, then random phases
// under several window and colour settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import mtrlp_pkg::*;

    localparam int LINE_W        = LINE_WIDTH_DEF;
    localparam int NUM_REGS      = 8;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 140;
    localparam int SETTLE_CYCLES = 8;       // plot/start write-back still in flight
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRESSURE_PH   = 3;
    localparam int STEADY_PH     = 5;
    localparam int MAX_REPORTS   = 10;

    localparam logic [1:0] OP_NONE = 2'd3;  // undefined code, ignored by the block

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  scanline;
        logic [7:0]  tile_x;
        logic [15:0] pattern;
        logic        mirror;
        logic [1:0]  pal_sel;
        logic        pal_high;
        logic [7:0]  depth;
        logic [7:0]  read_x;
    } tile_item_t;

    typedef struct packed {
        logic [15:0] colour;
        logic [7:0]  depth;
    } pixel_t;

    // Result typed into the directed table, or a marker to use the model
    typedef struct packed {
        logic   known;
        pixel_t px;
    } typed_pixel_t;

    typedef struct packed {
        tile_item_t   item;
        typed_pixel_t res;
    } dir_row_t;

    typedef struct packed {
        logic [7:0]  win_x;
        logic [7:0]  win_y;
        logic [7:0]  win_w;
        logic [7:0]  win_h;
        logic        neg;
        logic [2:0]  win_col;
        logic [7:0]  bg_ctrl;
        logic [53:0] pal;
    } setting_t;

    // DUT ports
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Line buffer model and its settings
    logic [15:0] model_colour [LINE_W];
    logic [7:0]  model_depth  [LINE_W];
    setting_t    cur_setting;

    typed_pixel_t typed_pixel_q [$];   // one per offered item, in order
    pixel_t       pending_pixels [$];  // read results still to arrive
    dir_row_t     dir_rows [$];

    logic steady_flow = 1'b0;
    logic hold_req    = 1'b0;
    int   failures    = 0;
    int   items_taken = 0;
    int   pixels_checked = 0;
    int   cycle_count = 0;
    int   hold_count  = 0;
    logic hold_done   = 1'b0;

    mono_tile_row_line_plotter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Line buffer model
    // ------------------------------------------------------------------------
    function automatic logic [15:0] grey_rgb(input logic [2:0] g);
        logic [15:0] w;
        w = 16'(g);
        return (w << 1) | (w << 5) | (w << 9);
    endfunction

    function automatic logic [15:0] display_tone(input logic [2:0] g);
        return cur_setting.neg ? grey_rgb(g) : ~grey_rgb(g);
    endfunction

    function automatic logic in_window_col(input int x);
        int right;
        right = int'(cur_setting.win_x) + int'(cur_setting.win_w);
        return x >= int'(cur_setting.win_x) && x < right && x < LINE_W;
    endfunction

    task automatic fill_line(input logic [7:0] scanline);
        logic [15:0] outer;
        logic [15:0] back;
        logic        rows;
        outer = display_tone(cur_setting.win_col);
        if ((cur_setting.bg_ctrl & BG_ENABLE_MASK) == BG_ENABLE_CODE) begin
            back = ~grey_rgb(cur_setting.bg_ctrl[2:0]);
        end else begin
            back = BACK_DEFAULT;
        end
        if (cur_setting.neg) begin
            back = ~back;
        end
        rows = int'(scanline) >= int'(cur_setting.win_y) &&
               int'(scanline) < int'(cur_setting.win_y) + int'(cur_setting.win_h);
        for (int x = 0; x < LINE_W; x++) begin
            model_depth[x]  = '0;
            model_colour[x] = (rows && in_window_col(x)) ? back : outer;
        end
    endtask

    task automatic plot_tile_row(input tile_item_t it);
        logic [1:0] pal;
        logic [1:0] idx;
        logic [7:0] x;
        int         entry;
        pal = (it.pal_sel > PAL_SPRITE) ? PAL_SPRITE : it.pal_sel;
        for (int k = 0; k < NUM_LANES; k++) begin
            idx = 2'((it.pattern >> (14 - 2 * k)) & 16'd3);
            x   = it.tile_x + (it.mirror ? 8'(7 - k) : 8'(k));
            if (idx == 2'd0 || !in_window_col(int'(x))) continue;
            if (it.depth <= model_depth[x]) continue;
            model_depth[x]  = it.depth;
            entry           = int'(it.pal_high) * 3 + int'(idx) - 1;
            model_colour[x] = display_tone(cur_setting.pal[(6 * int'(pal) + entry) * 3 +: 3]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predict on input transfers, check output transfers
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        tile_item_t   it;
        typed_pixel_t tag;
        pixel_t       px;
        pixel_t       got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                it.op       = s_tuser;
                it.scanline = s_tdata[TD_SCANLINE_LSB +: 8];
                it.tile_x   = s_tdata[TD_TILE_X_LSB +: 8];
                it.pattern  = s_tdata[TD_PATTERN_LSB +: 16];
                it.mirror   = s_tdata[TD_MIRROR_LSB];
                it.pal_sel  = s_tdata[TD_PAL_SEL_LSB +: 2];
                it.pal_high = s_tdata[TD_PAL_HIGH_LSB];
                it.depth    = s_tdata[TD_DEPTH_LSB +: 8];
                it.read_x   = s_tdata[TD_READ_X_LSB +: 8];
                tag = typed_pixel_q.pop_front();
                items_taken++;
                case (it.op)
                    OP_START: fill_line(it.scanline);
                    OP_PLOT:  plot_tile_row(it);
                    OP_READ: begin
                        if (int'(it.read_x) < LINE_W) begin
                            px.colour = model_colour[it.read_x];
                            px.depth  = model_depth[it.read_x];
                        end else begin
                            px = '0;
                        end
                        pending_pixels.push_back(tag.known ? tag.px : px);
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.colour = m_tdata[15:0];
                got.depth  = m_tdata[23:16];
                if (pending_pixels.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("unexpected pixel transfer: colour %h depth %h",
                                 got.colour, got.depth);
                    end
                end else begin
                    px = pending_pixels.pop_front();
                    pixels_checked++;
                    if (got.colour !== px.colour || got.depth !== px.depth) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("pixel %0d mismatch: colour exp %h got %h, depth exp %h got %h",
                                     pixels_checked, px.colour, got.colour, px.depth, got.depth);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, always ready in the steady phase, one long hold-off in the pressure phase
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
        end else if (steady_flow) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 33);
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles", cycle_count);
            $display("[mono_tile_row_line_plotter_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic offer_item(input tile_item_t it, input typed_pixel_t res);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[TD_SCANLINE_LSB +: 8] = it.scanline;
        d[TD_TILE_X_LSB +: 8]   = it.tile_x;
        d[TD_PATTERN_LSB +: 16] = it.pattern;
        d[TD_MIRROR_LSB]        = it.mirror;
        d[TD_PAL_SEL_LSB +: 2]  = it.pal_sel;
        d[TD_PAL_HIGH_LSB]      = it.pal_high;
        d[TD_DEPTH_LSB +: 8]    = it.depth;
        d[TD_READ_X_LSB +: 8]   = it.read_x;
        if (!steady_flow && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= d;
        typed_pixel_q.push_back(res);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait for outstanding reads, then for in-flight writes to settle
    task automatic drain();
        int waited;
        waited = 0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(input setting_t st);
        logic [CFG_DATA_W-1:0] vals [NUM_REGS];
        vals[REG_WINDOW_X]      = CFG_DATA_W'(st.win_x);
        vals[REG_WINDOW_Y]      = CFG_DATA_W'(st.win_y);
        vals[REG_WINDOW_WIDTH]  = CFG_DATA_W'(st.win_w);
        vals[REG_WINDOW_HEIGHT] = CFG_DATA_W'(st.win_h);
        vals[REG_NEGATIVE_MODE] = CFG_DATA_W'(st.neg);
        vals[REG_WINDOW_COLOUR] = CFG_DATA_W'(st.win_col);
        vals[REG_BG_CONTROL]    = CFG_DATA_W'(st.bg_ctrl);
        vals[REG_PALETTES]      = CFG_DATA_W'(st.pal);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        cur_setting = st;
    endtask

    function automatic setting_t phase_setting(input int p);
        setting_t st;
        st.win_x   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 100));
        st.win_y   = 8'($urandom_range(0, 255));
        st.win_w   = 8'($urandom_range(0, 255));
        st.win_h   = 8'($urandom_range(0, 255));
        st.neg     = 1'($urandom_range(0, 1));
        st.win_col = 3'($urandom_range(0, 7));
        st.bg_ctrl = $urandom_range(0, 1) ? {2'b10, 6'($urandom)} : 8'($urandom);
        st.pal     = 54'({$urandom, $urandom});
        case (p)
            0: begin
                // full-size window, enabled background, all palette bits set
                st = '{win_x: 8'd0, win_y: 8'd0, win_w: 8'd255, win_h: 8'd255, neg: 1'b0,
                       win_col: 3'd7, bg_ctrl: 8'hBF, pal: '1};
            end
            1: begin
                // window starts past the line, background disabled by 2'b11
                st = '{win_x: 8'd255, win_y: 8'd255, win_w: 8'd255, win_h: 8'd255, neg: 1'b1,
                       win_col: 3'd0, bg_ctrl: 8'hC5, pal: '0};
            end
            2: begin
                // empty window
                st.win_w = 8'd0;
                st.win_h = 8'd0;
            end
            default: ;
        endcase
        return st;
    endfunction

    function automatic tile_item_t random_item(input int read_pct);
        tile_item_t it;
        int         r;
        it.scanline = 8'($urandom);
        it.tile_x   = 8'($urandom);
        it.pattern  = 16'($urandom);
        it.mirror   = 1'($urandom);
        it.pal_sel  = 2'($urandom);
        it.pal_high = 1'($urandom);
        it.depth    = 8'($urandom);
        it.read_x   = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8) begin
            it.op = OP_START;
            if ($urandom_range(0, 2) != 0) begin
                it.scanline = cur_setting.win_y + 8'($urandom_range(0, cur_setting.win_h));
            end
        end else if (r < 8 + read_pct) begin
            it.op     = OP_READ;
            it.read_x = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(LINE_W, 255))
                                                    : 8'($urandom_range(0, LINE_W - 1));
        end else if (r < 96) begin
            it.op = OP_PLOT;
            if ($urandom_range(0, 1) != 0) begin
                it.tile_x = cur_setting.win_x + 8'($urandom_range(0, cur_setting.win_w))
                          - 8'($urandom_range(0, 7));
            end
        end else begin
            it.op = OP_NONE;
        end
        return it;
    endfunction

    task automatic run_phase(input int n, input int read_pct);
        tile_item_t it;
        // open with a start-line so plots land on a fresh line
        do it = random_item(read_pct); while (it.op != OP_START);
        offer_item(it, '0);
        repeat (n - 1) begin
            it = random_item(read_pct);
            offer_item(it, '0);
        end
        s_tvalid <= 1'b0;
    endtask

    function automatic dir_row_t dir_row(input logic [1:0] op, input logic [7:0] scan,
                                         input logic [7:0] tx, input logic [15:0] pat,
                                         input logic mir, input logic [1:0] ps,
                                         input logic ph, input logic [7:0] dep,
                                         input logic [7:0] rx, input logic known,
                                         input logic [15:0] colour, input logic [7:0] pdep);
        dir_row_t row;
        row.item     = '{op: op, scanline: scan, tile_x: tx, pattern: pat, mirror: mir,
                         pal_sel: ps, pal_high: ph, depth: dep, read_x: rx};
        row.res      = '{known: known, px: '{colour: colour, depth: pdep}};
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        cur_setting = '{win_x: 8'd0, win_y: 8'd0, win_w: WINDOW_WIDTH_RST,
                        win_h: WINDOW_HEIGHT_RST, neg: 1'b0, win_col: 3'd0,
                        bg_ctrl: 8'd0, pal: '0};
        for (int x = 0; x < LINE_W; x++) begin
            model_colour[x] = '0;
            model_depth[x]  = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; typed results only where obvious from reset state
        // reads after reset, both line ends and past the line
        dir_rows.push_back(dir_row(OP_READ,  0, 0, 0, 0, 0, 0, 0, 0,   1, 16'h0000, 0));
        dir_rows.push_back(dir_row(OP_READ,  0, 0, 0, 0, 0, 0, 0, 159, 1, 16'h0000, 0));
        dir_rows.push_back(dir_row(OP_READ,  0, 0, 0, 0, 0, 0, 0, 255, 1, 16'h0000, 0));
        // undefined operation with every field at its top value
        dir_rows.push_back(dir_row(OP_NONE, 255, 255, 16'hFFFF, 1, 3, 1, 255, 255, 0, 0, 0));
        // first window row: default background over the whole line
        dir_rows.push_back(dir_row(OP_START, 0, 0, 0, 0, 0, 0, 0, 0,   0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ,  0, 0, 0, 0, 0, 0, 0, 0,   1, BACK_DEFAULT, 0));
        dir_rows.push_back(dir_row(OP_READ,  0, 0, 0, 0, 0, 0, 0, 159, 1, BACK_DEFAULT, 0));
        // opaque row at top depth, zero palette gives all-ones colour
        dir_rows.push_back(dir_row(OP_PLOT, 0, 0, 16'hFFFF, 0, 0, 0, 255, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 7, 1, 16'hFFFF, 255));
        // equal depth loses; saturating palette select, high entries
        dir_rows.push_back(dir_row(OP_PLOT, 0, 0, 16'h5555, 0, 3, 1, 255, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_PLOT, 0, 8, 16'h1B1B, 1, 3, 1, 1, 0, 0, 0, 0));
        // row running off the right end of the line
        dir_rows.push_back(dir_row(OP_PLOT, 0, 154, 16'hFFFF, 0, 1, 0, 10, 0, 0, 0, 0));
        // mirrored row wrapping past x 255
        dir_rows.push_back(dir_row(OP_PLOT, 0, 252, 16'hE4E4, 1, 2, 0, 200, 0, 0, 0, 0));
        // depth zero never wins, all-transparent row writes nothing
        dir_rows.push_back(dir_row(OP_PLOT, 0, 16, 16'hFFFF, 0, 0, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_PLOT, 0, 24, 16'h0000, 0, 1, 1, 100, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 3,   0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 11,  0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 15,  0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 159, 0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 160, 1, 16'h0000, 0));
        // below the window rows: outer colour
        dir_rows.push_back(dir_row(OP_START, 255, 0, 0, 0, 0, 0, 0, 0,  0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ,  0, 0, 0, 0, 0, 0, 0, 80,   1, 16'hFFFF, 0));
        // last row inside, first row outside
        dir_rows.push_back(dir_row(OP_START, 151, 0, 0, 0, 0, 0, 0, 0,  0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ,  0, 0, 0, 0, 0, 0, 0, 80,   1, BACK_DEFAULT, 0));
        dir_rows.push_back(dir_row(OP_START, 152, 0, 0, 0, 0, 0, 0, 0,  0, 0, 0));
        dir_rows.push_back(dir_row(OP_READ,  0, 0, 0, 0, 0, 0, 0, 80,   1, 16'hFFFF, 0));

        foreach (dir_rows[i]) begin
            offer_item(dir_rows[i].item, dir_rows[i].res);
        end
        s_tvalid <= 1'b0;
        drain();

        // Random phases, one setting each
        for (int p = 0; p < NUM_PHASES; p++) begin
            hold_req    <= (p == PRESSURE_PH);
            steady_flow <= (p == STEADY_PH);
            apply_setting(phase_setting(p));
            run_phase(PHASE_ITEMS, (p == PRESSURE_PH) ? 70 : 35);
            drain();
        end

        if (pending_pixels.size() != 0) begin
            failures += pending_pixels.size();
            $display("%0d pixel reads never returned", pending_pixels.size());
        end
        $display("covered %0d items (%0d pixel reads compared) over %0d window settings",
                 items_taken, pixels_checked, NUM_PHASES + 1);
        $display("failures: %0d, cycles: %0d", failures, cycle_count);
        if (failures == 0) begin
            $display("[mono_tile_row_line_plotter_core] OK");
        end else begin
            $display("[mono_tile_row_line_plotter_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/mtrlp_pkg.sv
hdl/mtrlp_ram.sv
hdl/mtrlp_lane.sv
hdl/mtrlp_merge.sv
hdl/mono_tile_row_line_plotter_core.sv
hdl/mtrlp_checker.sv
tb/sv/tb.sv
